// ===== hw/rtl/ealu_pkg.sv =====
package ealu_pkg;

    localparam int unsigned OpWidth   = 4;
    localparam int unsigned DataWidth = 8;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_CMP  = 4'd2,
        OP_ADDC = 4'd3,
        OP_MUL  = 4'd4,
        OP_XOR  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_DEC  = 4'd8,
        OP_INC  = 4'd9
    } ealu_op_t;

    typedef struct packed {
        logic [OpWidth-1:0]   operation;
        logic [DataWidth-1:0] operand_a;
        logic [DataWidth-1:0] operand_b;
        logic                 carry_in;
    } ealu_req_t;

    typedef struct packed {
        logic [DataWidth-1:0] result_a;
        logic [DataWidth-1:0] result_b;
        logic                 carry_out;
        logic                 zero_out;
    } ealu_res_t;

endpackage

// ===== hw/rtl/ealu_req_reg.sv =====
module ealu_req_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ealu_pkg::ealu_req_t in_req,
    output logic                req_valid,
    output ealu_pkg::ealu_req_t req,
    input  logic                down_ready
);
    import ealu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ealu_req_t req_reg;

    // hold the request while the result stage cannot take it
    assign in_stall   = valid_reg && !down_ready;
    assign valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== hw/rtl/ealu_core.sv =====
module ealu_core (
    input  ealu_pkg::ealu_req_t req,
    output ealu_pkg::ealu_res_t res
);
    import ealu_pkg::*;

    logic [DataWidth:0]     add_sum;
    logic [DataWidth:0]     addc_sum;
    logic [DataWidth:0]     diff;
    logic [2*DataWidth-1:0] prod;
    logic [DataWidth-1:0]   logic_val;

    always_comb
    begin
        add_sum   = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        addc_sum  = add_sum + {{DataWidth{1'b0}}, req.carry_in};
        diff      = {1'b0, req.operand_a} - {1'b0, req.operand_b};
        prod      = {{DataWidth{1'b0}}, req.operand_a} * {{DataWidth{1'b0}}, req.operand_b};
        logic_val = req.operand_a;

        // pass both registers through, clear both flags
        res.result_a  = req.operand_a;
        res.result_b  = req.operand_b;
        res.carry_out = 1'b0;
        res.zero_out  = 1'b0;

        case (req.operation)
            OP_ADD:
            begin
                res.result_a  = add_sum[DataWidth-1:0];
                res.carry_out = add_sum[DataWidth];
            end
            OP_SUB:
            begin
                res.result_a  = diff[DataWidth-1:0];
                res.zero_out  = (diff[DataWidth-1:0] == '0);
                res.carry_out = diff[DataWidth];
            end
            OP_CMP:
            begin
                res.zero_out  = (req.operand_a == req.operand_b);
                res.carry_out = diff[DataWidth];
            end
            OP_ADDC:
            begin
                res.result_a  = addc_sum[DataWidth-1:0];
                res.carry_out = addc_sum[DataWidth];
            end
            OP_MUL:
            begin
                res.result_a = prod[DataWidth-1:0];
                res.result_b = prod[2*DataWidth-1:DataWidth];
                res.zero_out = (prod == '0);
            end
            OP_XOR, OP_AND, OP_OR:
            begin
                if (req.operation == OP_XOR)
                begin
                    logic_val = req.operand_a ^ req.operand_b;
                end
                else if (req.operation == OP_AND)
                begin
                    logic_val = req.operand_a & req.operand_b;
                end
                else
                begin
                    logic_val = req.operand_a | req.operand_b;
                end
                res.result_a = logic_val;
                res.zero_out = (logic_val == '0);
            end
            OP_DEC:
            begin
                res.result_a = req.operand_a - DataWidth'(1);
                res.zero_out = (req.operand_a == DataWidth'(1));
            end
            OP_INC:
            begin
                res.result_a  = req.operand_a + DataWidth'(1);
                res.carry_out = (req.operand_a == {DataWidth{1'b1}});
            end
            default:
            begin
                res.result_a = req.operand_a;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ealu_res_reg.sv =====
module ealu_res_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  ealu_pkg::ealu_res_t up_res,
    output logic                out_valid,
    input  logic                out_stall,
    output ealu_pkg::ealu_res_t res
);
    import ealu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ealu_res_t res_reg;

    // take a new result whenever the held one is gone or leaving
    assign up_ready   = !valid_reg || !out_stall;
    assign valid_next = up_ready ? up_valid : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            res_reg <= up_res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/eight_bit_alu_with_flags.sv =====
// Eight-bit ALU with carry and zero flags. One request per cycle is taken while
// in_stall is low, and each gives one result: the request is captured in an
// input register, all ten operations (8x8 multiply included) are evaluated
// in one pass of logic, and the result lands in an output register. The
// 8x8 multiplier between the two registers sets the cycle time. Both flags
// start cleared for every request; undefined operation codes pass the
// operands through with both flags clear. A held result does not block the
// input register, so one request can still be taken while out_stall is high.
module eight_bit_alu_with_flags (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ealu_pkg::OpWidth-1:0]       operation,
    input  logic [ealu_pkg::DataWidth-1:0]     operand_a,
    input  logic [ealu_pkg::DataWidth-1:0]     operand_b,
    input  logic                               carry_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ealu_pkg::DataWidth-1:0]     result_a,
    output logic [ealu_pkg::DataWidth-1:0]     result_b,
    output logic                               carry_out,
    output logic                               zero_out
);
    import ealu_pkg::*;

    ealu_req_t in_req;
    ealu_req_t req;
    ealu_res_t core_res;
    ealu_res_t res;
    logic      req_valid;
    logic      res_ready;

    assign in_req.operation = operation;
    assign in_req.operand_a = operand_a;
    assign in_req.operand_b = operand_b;
    assign in_req.carry_in  = carry_in;

    ealu_req_reg u_req_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_req     (in_req),
        .req_valid  (req_valid),
        .req        (req),
        .down_ready (res_ready)
    );

    ealu_core u_core (
        .req (req),
        .res (core_res)
    );

    ealu_res_reg u_res_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (req_valid),
        .up_ready  (res_ready),
        .up_res    (core_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign result_a  = res.result_a;
    assign result_b  = res.result_b;
    assign carry_out = res.carry_out;
    assign zero_out  = res.zero_out;

    // a stall upstream only comes from a full, stalled pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (req_valid && out_valid && out_stall))
        else $error("input stalled without a held result");

    // a request leaving the input register shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && res_ready) |=> out_valid)
        else $error("request lost between stages");

    // no operation can raise both flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(carry_out && zero_out))
        else $error("carry and zero both set");

    // an open output never backs up the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is open");

endmodule
